// File: sv/qte_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and CORDIC step functions for the quaternion to
// Euler angle converter. No dependencies.
package qte_pkg;

  localparam int MAX_STEPS = 24;
  localparam int CW = 40;      // CORDIC x/y datapath width
  localparam int NW = 36;      // numerator/denominator width, Q.30
  localparam int SQ_BITS = 31; // square root result width

  localparam logic [31:0] ATAN_TAB [MAX_STEPS] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
    32'd21354465, 32'd10680862, 32'd5340245, 32'd2670163, 32'd1335087,
    32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
    32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163, 32'd81
  };

  typedef struct packed {
    logic                 zero;
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic [31:0]          acc;
  } cordic_t;

  typedef struct packed {
    logic signed [NW-1:0] roll_n;
    logic signed [NW-1:0] roll_d;
    logic signed [NW-1:0] yaw_n;
    logic signed [NW-1:0] yaw_d;
    logic signed [31:0]   s;
  } operands_t;

  // Fold the vector into the right half plane and flag the null vector
  function automatic cordic_t cordic_init(logic signed [CW-1:0] y,
                                          logic signed [CW-1:0] x);
    cordic_t c;
    c.zero = (x == '0) && (y == '0);
    if (x < 0) begin
      c.x = -x;
      c.y = -y;
      c.acc = 32'h8000_0000;
    end else begin
      c.x = x;
      c.y = y;
      c.acc = '0;
    end
    return c;
  endfunction

  // One vectoring rotation towards the x axis
  function automatic cordic_t cordic_step(cordic_t c, int i);
    cordic_t r;
    logic signed [CW-1:0] dx;
    logic signed [CW-1:0] dy;
    dx = c.x >>> i;
    dy = c.y >>> i;
    r.zero = c.zero;
    if (c.y < 0) begin
      r.x = c.x - dy;
      r.y = c.y + dx;
      r.acc = c.acc - ATAN_TAB[i];
    end else begin
      r.x = c.x + dy;
      r.y = c.y - dx;
      r.acc = c.acc + ATAN_TAB[i];
    end
    return r;
  endfunction

  // Round the accumulator half up to a 16-bit binary angle
  function automatic logic [15:0] to_angle(cordic_t c);
    logic [31:0] r;
    r = c.acc + 32'h0000_8000;
    return c.zero ? 16'h0000 : r[31:16];
  endfunction

endpackage

// File: sv/quaternion_to_euler_angles.sv
`timescale 1ns / 1ps
// Quaternion to ZYX Euler angles (roll, pitch, yaw), fully pipelined.
// Depends on qte_pkg.
//
// Accepts one quaternion every clock cycle; busy never rises. Each request
// produces its angles on the result ports, marked by done for one cycle.
// A request passes through stages A to D, stage E, the 31-stage bit-per-stage
// square root feeding the pitch CORDIC, the CORDIC set-up register, one stage
// per CORDIC iteration and the output register.
// No back-pressure exists: results must be taken in the cycle they appear.
module quaternion_to_euler_angles
  import qte_pkg::*;
#(
  parameter int CORDIC_STEPS = 16,
  parameter int QUAT_BITS    = 16
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  logic signed [QUAT_BITS-1:0] quat_w,
  input  logic signed [QUAT_BITS-1:0] quat_x,
  input  logic signed [QUAT_BITS-1:0] quat_y,
  input  logic signed [QUAT_BITS-1:0] quat_z,
  output logic                        done,
  output logic signed [15:0]          roll_angle,
  output logic signed [15:0]          pitch_angle,
  output logic signed [15:0]          yaw_angle
);

  localparam int STEPS = (CORDIC_STEPS > MAX_STEPS) ? MAX_STEPS :
                         (CORDIC_STEPS < 1) ? 1 : CORDIC_STEPS;
  localparam int FB  = 2 * (QUAT_BITS - 1);
  localparam int SHR = (FB >= 30) ? FB - 30 : 0;
  localparam int SHL = (FB < 30) ? 30 - FB : 0;

  localparam logic signed [NW-1:0] ONE_Q30 = NW'(64'sd1 <<< 30);
  localparam logic signed [NW-1:0] NEG_ONE_Q30 = -ONE_Q30;

  // Product of two components brought to Q.30
  function automatic logic signed [31:0] mul_q30(logic signed [QUAT_BITS-1:0] a,
                                                 logic signed [QUAT_BITS-1:0] b);
    logic signed [2*QUAT_BITS-1:0] p;
    logic signed [63:0] e;
    p = a * b;
    e = 64'(p);
    e = (e >>> SHR) <<< SHL;
    return e[31:0];
  endfunction

  assign busy = 1'b0;

  // Stage A: register the request
  logic va;
  logic signed [QUAT_BITS-1:0] a_w, a_x, a_y, a_z;

  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
    end else begin
      va <= start;
    end
    a_w <= quat_w;
    a_x <= quat_x;
    a_y <= quat_y;
    a_z <= quat_z;
  end

  // Stage B: the nine component products
  logic vb;
  logic signed [31:0] p_wx, p_yz, p_xx, p_yy, p_wz, p_xy, p_zz, p_wy, p_zx;

  always_ff @(posedge clk) begin
    if (rst) begin
      vb <= 1'b0;
    end else begin
      vb <= va;
    end
    p_wx <= mul_q30(a_w, a_x);
    p_yz <= mul_q30(a_y, a_z);
    p_xx <= mul_q30(a_x, a_x);
    p_yy <= mul_q30(a_y, a_y);
    p_wz <= mul_q30(a_w, a_z);
    p_xy <= mul_q30(a_x, a_y);
    p_zz <= mul_q30(a_z, a_z);
    p_wy <= mul_q30(a_w, a_y);
    p_zx <= mul_q30(a_z, a_x);
  end

  // Stage C: numerators, denominators and the clamped sine of pitch
  logic vc;
  operands_t c_op;
  logic signed [NW-1:0] s_raw;
  logic signed [NW-1:0] s_sat;

  always_comb begin
    s_raw = (NW'(p_wy) - NW'(p_zx)) <<< 1;
    if (s_raw > ONE_Q30) begin
      s_sat = ONE_Q30;
    end else if (s_raw < NEG_ONE_Q30) begin
      s_sat = NEG_ONE_Q30;
    end else begin
      s_sat = s_raw;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vc <= 1'b0;
    end else begin
      vc <= vb;
    end
    c_op.roll_n <= (NW'(p_wx) + NW'(p_yz)) <<< 1;
    c_op.roll_d <= ONE_Q30 - ((NW'(p_xx) + NW'(p_yy)) <<< 1);
    c_op.yaw_n  <= (NW'(p_wz) + NW'(p_xy)) <<< 1;
    c_op.yaw_d  <= ONE_Q30 - ((NW'(p_yy) + NW'(p_zz)) <<< 1);
    c_op.s      <= s_sat[31:0];
  end

  // Stage D: square the sine
  logic vd;
  operands_t d_op;
  logic [SQ_BITS-1:0] s_abs;
  logic [61:0] d_sq;

  assign s_abs = c_op.s[31] ? SQ_BITS'(-c_op.s) : SQ_BITS'(c_op.s);

  always_ff @(posedge clk) begin
    if (rst) begin
      vd <= 1'b0;
    end else begin
      vd <= vc;
    end
    d_op <= c_op;
    d_sq <= 62'(s_abs) * 62'(s_abs);
  end

  // Stage E and square root: one result bit per stage, from the top
  logic                 sq_v    [0:SQ_BITS];
  operands_t            sq_op   [0:SQ_BITS];
  logic [61:0]          sq_rem  [0:SQ_BITS];
  logic [SQ_BITS-1:0]   sq_root [0:SQ_BITS];

  always_ff @(posedge clk) begin
    if (rst) begin
      sq_v[0] <= 1'b0;
    end else begin
      sq_v[0] <= vd;
    end
    sq_op[0]   <= d_op;
    sq_rem[0]  <= (62'd1 << 60) - d_sq;
    sq_root[0] <= '0;
  end

  for (genvar j = 0; j < SQ_BITS; j++) begin : g_sqrt
    localparam int K = SQ_BITS - 1 - j;
    logic [61:0] trial;

    assign trial = (62'(sq_root[j]) << (K + 1)) + (62'd1 << (2 * K));

    always_ff @(posedge clk) begin
      if (rst) begin
        sq_v[j+1] <= 1'b0;
      end else begin
        sq_v[j+1] <= sq_v[j];
      end
      sq_op[j+1] <= sq_op[j];
      if (sq_rem[j] >= trial) begin
        sq_rem[j+1]  <= sq_rem[j] - trial;
        sq_root[j+1] <= sq_root[j] | (SQ_BITS'(1) << K);
      end else begin
        sq_rem[j+1]  <= sq_rem[j];
        sq_root[j+1] <= sq_root[j];
      end
    end
  end

  // CORDIC set-up and iterations for the three angles
  logic    cv [0:STEPS];
  cordic_t cr [0:STEPS];
  cordic_t cp [0:STEPS];
  cordic_t cy [0:STEPS];

  always_ff @(posedge clk) begin
    if (rst) begin
      cv[0] <= 1'b0;
    end else begin
      cv[0] <= sq_v[SQ_BITS];
    end
    cr[0] <= cordic_init(CW'(sq_op[SQ_BITS].roll_n), CW'(sq_op[SQ_BITS].roll_d));
    cp[0] <= cordic_init(CW'(sq_op[SQ_BITS].s),
                         CW'({1'b0, sq_root[SQ_BITS]}));
    cy[0] <= cordic_init(CW'(sq_op[SQ_BITS].yaw_n), CW'(sq_op[SQ_BITS].yaw_d));
  end

  for (genvar i = 0; i < STEPS; i++) begin : g_cordic
    always_ff @(posedge clk) begin
      if (rst) begin
        cv[i+1] <= 1'b0;
      end else begin
        cv[i+1] <= cv[i];
      end
      cr[i+1] <= cordic_step(cr[i], i);
      cp[i+1] <= cordic_step(cp[i], i);
      cy[i+1] <= cordic_step(cy[i], i);
    end
  end

  // Output register: round and strobe the result
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cv[STEPS];
    end
    roll_angle  <= to_angle(cr[STEPS]);
    pitch_angle <= to_angle(cp[STEPS]);
    yaw_angle   <= to_angle(cy[STEPS]);
  end

endmodule
